>>> rtl/core/sbr_pkg.sv
// sbr_pkg: types and constants shared by the spi slave register bridge
// holds item structs, the memory request struct and the store geometry
// no dependencies
package sbr_pkg;

   // store geometry
   localparam int BYTE_REG_COUNT   = 16;
   localparam int WORD_STORE_DEPTH = 256;
   localparam int BYTE_AW          = $clog2(BYTE_REG_COUNT);
   localparam int WORD_AW          = $clog2(WORD_STORE_DEPTH);

   // command byte fields
   localparam int RD_BIT      = 7;
   localparam int AUTOINC_BIT = 6;

   // slot numbers within a frame
   localparam logic [2:0] SLOT_CMD     = 3'd0;
   localparam logic [2:0] SLOT_ADDR_HI = 3'd1;
   localparam logic [2:0] SLOT_ADDR_LO = 3'd2;
   localparam logic [2:0] SLOT_MAX     = 3'd5;

   // last byte lane of a word
   localparam logic [1:0] LANE_LAST = 2'd3;

   // configuration
   localparam logic [7:0] ID_RESET          = 8'hA5;
   localparam logic       CSR_PROTOCOL_MODE = 1'b0;
   localparam logic       CSR_ID_VALUE      = 1'b1;
   localparam logic       MODE_BYTE         = 1'b0;

   // what the miso byte of an item is made of
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_ID,
      KIND_BYTE_READ,
      KIND_WORD_READ
   } sbr_kind_type;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] mosi_byte;
   } sbr_req_type;

   typedef struct packed {
      logic [7:0] miso_byte;
      logic       read_data_valid;
      logic       write_committed;
   } sbr_rsp_type;

   // memory accesses and result description of one accepted item
   typedef struct packed {
      logic               byte_we;
      logic               byte_re;
      logic [BYTE_AW-1:0] byte_addr;
      logic [7:0]         byte_wdata;
      logic               word_we;
      logic               word_re;
      logic [WORD_AW-1:0] word_addr;
      logic [31:0]        word_wdata;
      sbr_kind_type       kind;
      logic [1:0]         lane;
      logic               commit;
   } sbr_op_type;

endpackage

>>> rtl/core/spi_slave_register_bridge.sv
// Device side of a chip-select framed SPI register link, one byte slot per
// item. Items are taken one per clock cycle back to back while req_stall is
// low; each gives one result, through stage one (synchronous store read)
// and then the output register. After reset the block sweeps both stores to
// zero through their write ports, one entry a cycle, over every word store
// address; req_stall stays high during that sweep, while configuration
// writes are taken as ever. Configure only while idle.
// Depends on sbr_pkg, sbr_ctrl and sbr_ram.
module spi_slave_register_bridge
   import sbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sbr_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sbr_rsp_type rsp_item,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic               mode_ff;
   logic [7:0]         id_ff;
   logic               clr_busy_ff;
   logic [WORD_AW-1:0] clr_cnt_ff;

   logic               accept;
   sbr_op_type         op;
   logic [7:0]         id_byte;

   logic               byte_we, word_we;
   logic [BYTE_AW-1:0] byte_waddr;
   logic [WORD_AW-1:0] word_waddr;
   logic [7:0]         byte_wdata;
   logic [31:0]        word_wdata;
   logic [7:0]         byte_rdata;
   logic [31:0]        word_rdata;

   logic               s1_valid_ff;
   sbr_kind_type       s1_kind_ff;
   logic [1:0]         s1_lane_ff;
   logic [7:0]         s1_id_ff;
   logic               s1_commit_ff;
   logic               s1_move;

   logic               rsp_valid_ff;
   sbr_rsp_type        rsp_item_ff, rsp_item_in;
   logic [7:0]         word_lane_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BYTE;
         id_ff   <= ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROTOCOL_MODE: mode_ff <= csr_wdata[0];
            CSR_ID_VALUE:      id_ff   <= csr_wdata;
            default:           id_ff   <= id_ff;
         endcase
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == WORD_AW'(WORD_STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // handshake: stage one holds while the output register is full and stalled
   assign s1_move   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = clr_busy_ff | (s1_valid_ff & ~s1_move);
   assign accept    = req_valid & ~req_stall;

   sbr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_item      (req_item),
      .protocol_mode (mode_ff),
      .id_value      (id_ff),
      .op            (op),
      .id_byte       (id_byte)
   );

   // write port mux between sweep and item writes
   always_comb begin
      if (clr_busy_ff) begin
         byte_we    = 1'b1;
         byte_waddr = clr_cnt_ff[BYTE_AW-1:0];
         byte_wdata = '0;
         word_we    = 1'b1;
         word_waddr = clr_cnt_ff;
         word_wdata = '0;
      end else begin
         byte_we    = op.byte_we;
         byte_waddr = op.byte_addr;
         byte_wdata = op.byte_wdata;
         word_we    = op.word_we;
         word_waddr = op.word_addr;
         word_wdata = op.word_wdata;
      end
   end

   sbr_ram #(
      .WIDTH (8),
      .DEPTH (BYTE_REG_COUNT)
   ) u_byte_ram (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (byte_wdata),
      .re    (op.byte_re),
      .raddr (op.byte_addr),
      .rdata (byte_rdata)
   );

   sbr_ram #(
      .WIDTH (32),
      .DEPTH (WORD_STORE_DEPTH)
   ) u_word_ram (
      .clock (clock),
      .we    (word_we),
      .waddr (word_waddr),
      .wdata (word_wdata),
      .re    (op.word_re),
      .raddr (op.word_addr),
      .rdata (word_rdata)
   );

   // stage one: item waiting for store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= op.kind;
         s1_lane_ff   <= op.lane;
         s1_id_ff     <= id_byte;
         s1_commit_ff <= op.commit;
      end
   end

   // msb-first byte of the read word
   always_comb begin
      unique case (s1_lane_ff)
         2'd0:    word_lane_byte = word_rdata[31:24];
         2'd1:    word_lane_byte = word_rdata[23:16];
         2'd2:    word_lane_byte = word_rdata[15:8];
         default: word_lane_byte = word_rdata[7:0];
      endcase
   end

   // result formation
   always_comb begin
      rsp_item_in.write_committed = s1_commit_ff;
      rsp_item_in.read_data_valid = 1'b0;
      unique case (s1_kind_ff)
         KIND_ID: begin
            rsp_item_in.miso_byte = s1_id_ff;
         end
         KIND_BYTE_READ: begin
            rsp_item_in.miso_byte       = byte_rdata;
            rsp_item_in.read_data_valid = 1'b1;
         end
         KIND_WORD_READ: begin
            rsp_item_in.miso_byte       = word_lane_byte;
            rsp_item_in.read_data_valid = 1'b1;
         end
         default: begin
            rsp_item_in.miso_byte = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/core/sbr_ram.sv
// sbr_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module sbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/sbr_ctrl.sv
// sbr_ctrl: frame sequencer of the spi slave register bridge
// tracks slot, command, address pointer and write word; issues store accesses
// depends on sbr_pkg
module sbr_ctrl
   import sbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  sbr_req_type req_item,
   input  logic        protocol_mode,
   input  logic [7:0]  id_value,
   output sbr_op_type  op,
   output logic [7:0]  id_byte
);

   logic [2:0]  slot_ff, slot_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  lane_ff, lane_in;

   logic [2:0]         slot;
   logic [BYTE_AW-1:0] byte_addr;
   logic [WORD_AW-1:0] word_addr;
   logic [WORD_AW-1:0] word_addr_inc;
   logic [15:0]        addr_full;
   logic [31:0]        asm_next;

   assign id_byte = id_value;

   // current slot and derived addresses
   always_comb begin
      slot          = req_item.frame_start ? SLOT_CMD : slot_ff;
      byte_addr     = ptr_ff[BYTE_AW-1:0];
      word_addr     = ptr_ff[WORD_AW-1:0];
      word_addr_inc = word_addr + 1'b1;
      addr_full     = {ptr_ff[15:8], req_item.mosi_byte};
      asm_next      = {asm_ff[23:0], req_item.mosi_byte};
   end

   // slot decode, next state and store accesses
   always_comb begin
      slot_in = (slot < SLOT_MAX) ? slot + 3'd1 : SLOT_MAX;
      cmd_in  = cmd_ff;
      ptr_in  = ptr_ff;
      asm_in  = asm_ff;
      lane_in = lane_ff;

      op            = '0;
      op.kind       = KIND_ZERO;
      op.byte_addr  = byte_addr;
      op.byte_wdata = req_item.mosi_byte;
      op.word_addr  = word_addr;
      op.word_wdata = asm_next;
      op.lane       = lane_ff;

      if (slot == SLOT_CMD) begin
         // command slot: id out, frame state restarts
         op.kind = KIND_ID;
         cmd_in  = req_item.mosi_byte;
         lane_in = 2'd0;
         asm_in  = '0;
         ptr_in  = '0;
         ptr_in[BYTE_AW-1:0] = req_item.mosi_byte[BYTE_AW-1:0];
      end else if (protocol_mode == MODE_BYTE) begin
         // byte register access with auto-increment
         if (cmd_ff[RD_BIT]) begin
            op.kind    = KIND_BYTE_READ;
            op.byte_re = accept;
         end else begin
            op.byte_we = accept;
            op.commit  = 1'b1;
         end
         ptr_in = '0;
         ptr_in[BYTE_AW-1:0] = byte_addr + 1'b1;
      end else if (slot == SLOT_ADDR_HI) begin
         ptr_in  = {req_item.mosi_byte, 8'h00};
         lane_in = 2'd0;
      end else if (slot == SLOT_ADDR_LO) begin
         ptr_in  = '0;
         ptr_in[WORD_AW-1:0] = addr_full[WORD_AW-1:0];
         lane_in = 2'd0;
      end else if (cmd_ff[RD_BIT]) begin
         // word read, after two dummy slots
         if (slot >= SLOT_MAX) begin
            op.kind    = KIND_WORD_READ;
            op.word_re = accept;
            if (lane_ff == LANE_LAST && cmd_ff[AUTOINC_BIT]) begin
               ptr_in = '0;
               ptr_in[WORD_AW-1:0] = word_addr_inc;
            end
            lane_in = lane_ff + 2'd1;
         end
      end else begin
         // word write, stored on the last byte of the word
         asm_in = asm_next;
         if (lane_ff == LANE_LAST) begin
            op.word_we = accept;
            op.commit  = 1'b1;
            if (cmd_ff[AUTOINC_BIT]) begin
               ptr_in = '0;
               ptr_in[WORD_AW-1:0] = word_addr_inc;
            end
         end
         lane_in = lane_ff + 2'd1;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_CMD;
         cmd_ff  <= '0;
         ptr_ff  <= '0;
         asm_ff  <= '0;
         lane_ff <= '0;
      end else if (accept) begin
         slot_ff <= slot_in;
         cmd_ff  <= cmd_in;
         ptr_ff  <= ptr_in;
         asm_ff  <= asm_in;
         lane_ff <= lane_in;
      end
   end

endmodule

>>> bench/spi_slave_register_bridge_tb.sv
// spi_slave_register_bridge_tb: self-checking bench for the spi slave register bridge
// runs a directed table and then random framed traffic, each reply checked against a fixed table value or a predictor
// depends on sbr_pkg and spi_slave_register_bridge
module spi_slave_register_bridge_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbr_pkg::*;

   localparam logic MODE_WORD    = ~MODE_BYTE;
   localparam int   RANDOM_ITEMS = 1400;
   localparam int   SETTLE_CYCLES = 6;
   localparam int   CYCLE_LIMIT  = 200000;

   // one row of the directed table: a register write or an item
   typedef struct packed {
      logic        is_csr;
      logic        csr_idx;
      logic [7:0]  csr_val;
      sbr_req_type req;
      logic        typed;
      sbr_rsp_type rsp;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sbr_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sbr_rsp_type rsp_item;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   // predictor state and configuration copy
   logic        cfg_mode;
   logic [7:0]  cfg_id;
   int unsigned slot_num;
   logic [7:0]  cmd_byte;
   int unsigned addr_ptr;
   logic [31:0] wr_word;
   int unsigned lane;
   logic [7:0]  reg_mirror [BYTE_REG_COUNT];
   logic [31:0] word_mirror [WORD_STORE_DEPTH];

   sbr_rsp_type slot_replies_due [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          req_no_gaps = 1'b0;
   dir_row_type dir_tab [$];

   spi_slave_register_bridge dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("spi_slave_register_bridge_tb failed");
            $finish;
         end
      end
   end

   // miso byte, flags and state update for one accepted slot
   task automatic compute_slot_reply(input sbr_req_type item, output sbr_rsp_type reply);
      int unsigned slot;
      int unsigned ra;
      int unsigned wa;
      logic [31:0] w;
      reply = '0;
      slot = item.frame_start ? 0 : slot_num;
      if (slot == SLOT_CMD) begin
         // command slot always answers with the id byte
         reply.miso_byte = cfg_id;
         cmd_byte = item.mosi_byte;
         lane = 0;
         wr_word = '0;
         addr_ptr = int'(item.mosi_byte[6:0]) % BYTE_REG_COUNT;
      end else if (cfg_mode == MODE_BYTE) begin
         // byte register access with auto-increment
         ra = addr_ptr % BYTE_REG_COUNT;
         if (cmd_byte[RD_BIT]) begin
            reply.miso_byte = reg_mirror[ra];
            reply.read_data_valid = 1'b1;
         end else begin
            reg_mirror[ra] = item.mosi_byte;
            reply.write_committed = 1'b1;
         end
         addr_ptr = (addr_ptr + 1) % BYTE_REG_COUNT;
      end else if (slot == SLOT_ADDR_HI) begin
         addr_ptr = int'(item.mosi_byte) << 8;
         lane = 0;
      end else if (slot == SLOT_ADDR_LO) begin
         addr_ptr = ((addr_ptr & 32'hFF00) | item.mosi_byte) % WORD_STORE_DEPTH;
         lane = 0;
      end else if (cmd_byte[RD_BIT]) begin
         // word read, data only after the two dummy slots
         if (slot >= SLOT_MAX) begin
            wa = addr_ptr % WORD_STORE_DEPTH;
            w = word_mirror[wa];
            reply.miso_byte = w[8*(3-lane) +: 8];
            reply.read_data_valid = 1'b1;
            if (lane == LANE_LAST && cmd_byte[AUTOINC_BIT])
               addr_ptr = (wa + 1) % WORD_STORE_DEPTH;
            lane = (lane + 1) % 4;
         end
      end else begin
         // word write, committed on the last byte lane
         wr_word = {wr_word[23:0], item.mosi_byte};
         if (lane == LANE_LAST) begin
            wa = addr_ptr % WORD_STORE_DEPTH;
            word_mirror[wa] = wr_word;
            reply.write_committed = 1'b1;
            if (cmd_byte[AUTOINC_BIT])
               addr_ptr = (wa + 1) % WORD_STORE_DEPTH;
         end
         lane = (lane + 1) % 4;
      end
      slot_num = (slot < SLOT_MAX) ? slot + 1 : SLOT_MAX;
   endtask

   // hand one item over and queue its expected reply
   task automatic send_item(input sbr_req_type item, input logic typed,
                            input sbr_rsp_type typed_rsp);
      int gap;
      logic stalled;
      sbr_rsp_type reply;
      gap = req_no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      // stall is sampled mid-cycle, where it holds its value for the coming edge
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled !== 1'b0);
      compute_slot_reply(item, reply);
      slot_replies_due.push_back(typed ? typed_rsp : reply);
   endtask

   // let the block drain before touching its registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (slot_replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_PROTOCOL_MODE)
         cfg_mode = val[0];
      else
         cfg_id = val;
   endtask

   // table row builders
   function automatic dir_row_type free_row(logic fs, logic [7:0] mosi);
      dir_row_type r;
      r = '0;
      r.req = '{frame_start: fs, mosi_byte: mosi};
      return r;
   endfunction

   function automatic dir_row_type fixed_row(logic fs, logic [7:0] mosi, logic [7:0] miso,
                                            logic rdv, logic wc);
      dir_row_type r;
      r = free_row(fs, mosi);
      r.typed = 1'b1;
      r.rsp = '{miso_byte: miso, read_data_valid: rdv, write_committed: wc};
      return r;
   endfunction

   function automatic dir_row_type reg_row(logic idx, logic [7:0] val);
      dir_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   // result side: random stalls, compare each reply with the oldest expectation
   initial begin : miso_sink
      int hold;
      int quiet_left;
      sbr_rsp_type due;
      logic got_valid;
      sbr_rsp_type got_item;
      quiet_left = 0;
      forever begin
         if (quiet_left == 0 && $urandom_range(0, 39) == 0)
            quiet_left = $urandom_range(20, 60);
         hold = (quiet_left > 0) ? 0 : $urandom_range(0, 5);
         if (quiet_left > 0)
            quiet_left--;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // reply is sampled mid-cycle, before the edge that takes it
         do begin
            @(negedge clock);
            got_valid = rsp_valid;
            got_item = rsp_item;
            @(posedge clock);
         end while (got_valid !== 1'b1);
         if (slot_replies_due.size() == 0) begin
            $error("reply with nothing expected: miso_byte %h", got_item.miso_byte);
            fail_count++;
         end else begin
            due = slot_replies_due.pop_front();
            if (got_item.miso_byte !== due.miso_byte) begin
               $error("miso_byte expected %h got %h", due.miso_byte, got_item.miso_byte);
               fail_count++;
            end
            if (got_item.read_data_valid !== due.read_data_valid) begin
               $error("read_data_valid expected %b got %b",
                      due.read_data_valid, got_item.read_data_valid);
               fail_count++;
            end
            if (got_item.write_committed !== due.write_committed) begin
               $error("write_committed expected %b got %b",
                      due.write_committed, got_item.write_committed);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : driver
      int sent;
      int budget;
      int n_phase;
      int body;
      logic [7:0] cmd;
      logic [7:0] mosi;
      logic fs;

      cfg_mode = MODE_BYTE;
      cfg_id = ID_RESET;
      slot_num = 0;
      cmd_byte = '0;
      addr_ptr = 0;
      wr_word = '0;
      lane = 0;
      foreach (reg_mirror[i]) reg_mirror[i] = '0;
      foreach (word_mirror[i]) word_mirror[i] = '0;

      dir_tab = '{
         // byte mode, first item without frame start opens a frame
         fixed_row(1'b0, 8'h83, ID_RESET, 1'b0, 1'b0),
         fixed_row(1'b0, 8'h00, 8'h00, 1'b1, 1'b0),
         fixed_row(1'b1, 8'h0F, ID_RESET, 1'b0, 1'b0),
         fixed_row(1'b0, 8'hFF, 8'h00, 1'b0, 1'b1),
         // index wraps from the top register to register zero
         fixed_row(1'b0, 8'h00, 8'h00, 1'b0, 1'b1),
         free_row(1'b1, 8'h7F),
         free_row(1'b0, 8'h8F),
         free_row(1'b1, 8'h8F),
         free_row(1'b0, 8'h00),
         // word mode, write at the top address then wrap to zero
         reg_row(CSR_PROTOCOL_MODE, {7'd0, MODE_WORD}),
         reg_row(CSR_ID_VALUE, 8'h00),
         fixed_row(1'b1, 8'h40, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'hFF, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'hFF, 8'h00, 1'b0, 1'b0),
         free_row(1'b0, 8'hDE),
         free_row(1'b0, 8'hAD),
         free_row(1'b0, 8'hBE),
         fixed_row(1'b0, 8'hEF, 8'h00, 1'b0, 1'b1),
         // partial word, dropped at the next frame start
         free_row(1'b0, 8'h12),
         // word read without auto-increment
         reg_row(CSR_ID_VALUE, 8'hFF),
         fixed_row(1'b1, 8'h80, 8'hFF, 1'b0, 1'b0),
         fixed_row(1'b0, 8'h00, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'hFF, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'h00, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'h00, 8'h00, 1'b0, 1'b0),
         fixed_row(1'b0, 8'h00, 8'hDE, 1'b1, 1'b0),
         fixed_row(1'b0, 8'h00, 8'hAD, 1'b1, 1'b0),
         fixed_row(1'b0, 8'h00, 8'hBE, 1'b1, 1'b0),
         fixed_row(1'b0, 8'h00, 8'hEF, 1'b1, 1'b0),
         free_row(1'b0, 8'h00),
         // mode switched in the middle of a long frame
         reg_row(CSR_PROTOCOL_MODE, {7'd0, MODE_BYTE}),
         free_row(1'b0, 8'h55)
      };

      // reset
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            wait_idle();
            write_reg(dir_tab[i].csr_idx, dir_tab[i].csr_val);
         end else begin
            send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
         end
      end

      // random phases: new settings, then framed traffic with some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         write_reg(CSR_PROTOCOL_MODE, {7'd0, logic'($urandom_range(0, 1))});
         case ($urandom_range(0, 3))
            0: write_reg(CSR_ID_VALUE, 8'h00);
            1: write_reg(CSR_ID_VALUE, 8'hFF);
            default: write_reg(CSR_ID_VALUE, 8'($urandom));
         endcase
         req_no_gaps = ($urandom_range(0, 3) == 0);
         budget = $urandom_range(40, 160);
         n_phase = 0;
         while (n_phase < budget) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray item
               send_item('{frame_start: 1'($urandom), mosi_byte: 8'($urandom)}, 1'b0, '0);
               n_phase++;
            end else begin
               cmd = 8'($urandom);
               send_item('{frame_start: 1'b1, mosi_byte: cmd}, 1'b0, '0);
               n_phase++;
               body = (cfg_mode == MODE_WORD) ? $urandom_range(0, 14) : $urandom_range(0, 8);
               for (int k = 0; k < body; k++) begin
                  fs = ($urandom_range(0, 15) == 0);
                  mosi = 8'($urandom);
                  // keep word addresses on a few entries, both ends of the store
                  if (cfg_mode == MODE_WORD && k == 1 && $urandom_range(0, 3) != 0)
                     mosi = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                        : 8'($urandom_range(248, 255));
                  send_item('{frame_start: fs, mosi_byte: mosi}, 1'b0, '0);
                  n_phase++;
               end
            end
         end
         sent += n_phase;
      end

      // drain and finish
      req_valid <= 1'b0;
      while (slot_replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("spi_slave_register_bridge_tb passed");
      else
         $display("spi_slave_register_bridge_tb failed");
      $finish;
   end

endmodule
